// ----- design/rsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// rsfd_pkg
// Shared types and constants of the serial frame decoder.
// ----------------------------------------------------------------------------
package rsfd_pkg;

    // Frame layout
    localparam int unsigned POS_W       = 11;
    localparam int unsigned ID_W        = 4;
    localparam int unsigned OUT_CHANS   = 7;
    localparam logic [3:0]  LAST_POS    = 4'd15;
    localparam logic [15:0] GUARD_RESET = 16'd262;
    localparam logic [POS_W-1:0] CHAN0_RESET = 11'd1024;

    // Known system codes
    localparam logic [7:0] SYS_22MS_1024 = 8'h12;
    localparam logic [7:0] SYS_11MS_2048 = 8'hA2;
    localparam logic [7:0] SYS_22MS_2048 = 8'hB2;

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Command queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = QPTR_W + 1;

    // One channel update, optionally closing the frame
    typedef struct packed {
        logic              last;
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  pos;
        logic [7:0]        system;
        logic [7:0]        fade;
    } t_cmd;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- design/rsfd_front.sv -----
// ----------------------------------------------------------------------------
// rsfd_front
// Accepts bytes and ticks, tracks the frame position and the guard timer,
// and turns each completed word into a channel update command.
// ----------------------------------------------------------------------------
module rsfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_guard_wr_en,
    input  logic [15:0]         i_guard_wr_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_operation,
    input  logic [7:0]          i_rx_byte,
    input  rsfd_pkg::t_q_status i_q_status,
    output logic                o_push,
    output rsfd_pkg::t_cmd      o_cmd
);

    logic [15:0] r_guard_ticks;
    logic [15:0] r_guard, n_guard;
    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_fade, n_fade;
    logic [7:0]  r_system, n_system;
    logic [7:0]  r_high, n_high;
    logic        w_accept;
    logic        w_known;

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;
    assign w_known  = (i_rx_byte == rsfd_pkg::SYS_22MS_1024) ||
                      (i_rx_byte == rsfd_pkg::SYS_11MS_2048) ||
                      (i_rx_byte == rsfd_pkg::SYS_22MS_2048);

    // Build the command from the held high byte and the current low byte
    assign o_cmd.last   = (r_pos == rsfd_pkg::LAST_POS);
    assign o_cmd.id     = r_high[6:3];
    assign o_cmd.pos    = {r_high[2:0], i_rx_byte};
    assign o_cmd.system = r_system;
    assign o_cmd.fade   = r_fade;

    // Classify the word and compute the next frame state
    always_comb begin
        n_guard  = r_guard;
        n_pos    = r_pos;
        n_fade   = r_fade;
        n_system = r_system;
        n_high   = r_high;
        o_push   = 1'b0;
        if (w_accept) begin
            if (i_operation == rsfd_pkg::OP_TICK) begin
                if (r_guard != 16'd0) begin
                    n_guard = r_guard - 16'd1;
                end
            end else if (r_pos == 4'd0) begin
                // Drop idle bytes while the guard runs
                if (r_guard == 16'd0) begin
                    n_fade = i_rx_byte;
                    n_pos  = 4'd1;
                end
            end else if (r_pos == 4'd1) begin
                n_system = i_rx_byte;
                n_guard  = r_guard_ticks;
                n_pos    = w_known ? 4'd2 : 4'd0;
            end else if (!r_pos[0]) begin
                n_high = i_rx_byte;
                n_pos  = r_pos + 4'd1;
            end else begin
                o_push = 1'b1;
                n_pos  = (r_pos == rsfd_pkg::LAST_POS) ? 4'd0 : r_pos + 4'd1;
            end
        end
    end

    // Hold frame state and the guard setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard_ticks <= rsfd_pkg::GUARD_RESET;
            r_guard       <= 16'd0;
            r_pos         <= 4'd0;
            r_fade        <= 8'd0;
            r_system      <= 8'd0;
            r_high        <= 8'd0;
        end else begin
            if (i_guard_wr_en) begin
                r_guard_ticks <= i_guard_wr_data;
            end
            r_guard  <= n_guard;
            r_pos    <= n_pos;
            r_fade   <= n_fade;
            r_system <= n_system;
            r_high   <= n_high;
        end
    end

endmodule

// ----- design/rsfd_fifo.sv -----
// ----------------------------------------------------------------------------
// rsfd_fifo
// Short command queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module rsfd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rsfd_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output rsfd_pkg::t_cmd      o_cmd,
    output rsfd_pkg::t_q_status o_status
);

    rsfd_pkg::t_cmd                  r_mem [rsfd_pkg::QDEPTH];
    logic [rsfd_pkg::QPTR_W-1:0]     r_wr;
    logic [rsfd_pkg::QPTR_W-1:0]     r_rd;
    logic [rsfd_pkg::QCNT_W-1:0]     r_cnt;

    assign o_status.full  = (r_cnt == rsfd_pkg::QCNT_W'(rsfd_pkg::QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_cmd          = r_mem[r_rd];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- design/rsfd_back.sv -----
// ----------------------------------------------------------------------------
// rsfd_back
// Applies channel updates to the channel table and registers the frame
// result when the closing word of a frame is applied.
// ----------------------------------------------------------------------------
module rsfd_back #(
    parameter int unsigned CHANNELS = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsfd_pkg::t_q_status i_q_status,
    input  rsfd_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_system_code,
    output logic [7:0]          o_fade_count,
    output logic [rsfd_pkg::OUT_CHANS-1:0][rsfd_pkg::POS_W-1:0] o_chan
);

    logic [rsfd_pkg::POS_W-1:0] r_table [CHANNELS];
    logic [rsfd_pkg::POS_W-1:0] n_table [CHANNELS];
    logic [rsfd_pkg::OUT_CHANS-1:0][rsfd_pkg::POS_W-1:0] r_chan, n_chan;
    logic       r_valid;
    logic [7:0] r_system;
    logic [7:0] r_fade;

    assign o_pop         = !i_q_status.empty && (!r_valid || i_ready);
    assign o_valid       = r_valid;
    assign o_system_code = r_system;
    assign o_fade_count  = r_fade;
    assign o_chan        = r_chan;

    // Write the addressed entry; ids beyond the table are ignored
    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            n_table[k] = r_table[k];
            if (o_pop && (i_cmd.id == rsfd_pkg::ID_W'(k))) begin
                n_table[k] = i_cmd.pos;
            end
        end
    end

    // Map table entries onto the fixed output lanes
    always_comb begin
        for (int j = 0; j < rsfd_pkg::OUT_CHANS; j++) begin
            n_chan[j] = '0;
            if (j < CHANNELS) begin
                n_chan[j] = n_table[j];
            end
        end
    end

    // Hold the channel table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_table[k] <= (k == 0) ? rsfd_pkg::CHAN0_RESET : '0;
            end
        end else begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_table[k] <= n_table[k];
            end
        end
    end

    // Load the result word on frame close, drop valid when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && i_cmd.last) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.last) begin
            r_system <= i_cmd.system;
            r_fade   <= i_cmd.fade;
            r_chan   <= n_chan;
        end
    end

endmodule

// ----- design/rc_serial_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder
// Decodes 16-byte radio-control receiver frames from received bytes and
// timer ticks and emits the channel table when a frame completes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready): each word is either a received byte
//   (i_operation = 0, i_rx_byte) or one timer tick (i_operation = 1).
//   Output channel (o_valid / i_ready): one word per completed frame with
//   the system byte, fade byte and channels 0..6.
//   Guard setting: i_guard_wr_en / i_guard_wr_data load the guard length.
// Timing:
//   One input word is taken per cycle while the queue is not full. Taking the
//   sixteenth byte of a frame writes the closing command into the queue;
//   when the back stage pops that command it updates the table and loads the
//   output register, raising o_valid. Sustained rate is one word per cycle.
// Reset:
//   Frame position idle, guard timer zero, guard length 262, channel 0 at
//   1024 and the others zero, queue empty, no result pending.
// Stall:
//   A held result stays in the output register; the back stage stops
//   draining the four-entry queue, and o_ready drops once it is full.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder #(
    parameter int unsigned CHANNELS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_guard_wr_en,
    input  logic [15:0] i_guard_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_system_code,
    output logic [7:0]  o_fade_count,
    output logic [10:0] o_chan0,
    output logic [10:0] o_chan1,
    output logic [10:0] o_chan2,
    output logic [10:0] o_chan3,
    output logic [10:0] o_chan4,
    output logic [10:0] o_chan5,
    output logic [10:0] o_chan6
);

    rsfd_pkg::t_q_status w_q_stat;
    rsfd_pkg::t_cmd      w_push_cmd;
    rsfd_pkg::t_cmd      w_q_out;
    logic                w_push;
    logic                w_pop;
    logic [rsfd_pkg::OUT_CHANS-1:0][rsfd_pkg::POS_W-1:0] w_chan;

    rsfd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_guard_wr_en   (i_guard_wr_en),
        .i_guard_wr_data (i_guard_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_rx_byte       (i_rx_byte),
        .i_q_status      (w_q_stat),
        .o_push          (w_push),
        .o_cmd           (w_push_cmd)
    );

    rsfd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_q_out),
        .o_status (w_q_stat)
    );

    rsfd_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_stat),
        .i_cmd         (w_q_out),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_system_code (o_system_code),
        .o_fade_count  (o_fade_count),
        .o_chan        (w_chan)
    );

    // Split the result lanes onto the ports
    assign o_chan0 = w_chan[0];
    assign o_chan1 = w_chan[1];
    assign o_chan2 = w_chan[2];
    assign o_chan3 = w_chan[3];
    assign o_chan4 = w_chan[4];
    assign o_chan5 = w_chan[5];
    assign o_chan6 = w_chan[6];

    // Queue never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("command queue overflow");

    // Queue never read while empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("command queue underflow");

    // A new result only follows a frame-closing command
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_pop && w_q_out.last))
        else $error("result raised without a closing command");

endmodule
